[rtl/per_key_rate_limiter_top_assert.svh]
// Assertion macros for the per-key rate limiter.
`ifndef PER_KEY_RATE_LIMITER_TOP_ASSERT_SVH
`define PER_KEY_RATE_LIMITER_TOP_ASSERT_SVH

`ifndef SYNTHESIS
// Same-cycle implication, clocked on clk, off while in reset.
`define PKRL_ASSERT_SAME(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("pkrl assertion failed");
// Next-cycle implication, clocked on clk, off while in reset.
`define PKRL_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("pkrl assertion failed");
`else
`define PKRL_ASSERT_SAME(lbl, ante, cons)
`define PKRL_ASSERT_NEXT(lbl, ante, cons)
`endif

`endif

[rtl/pkrl_pkg.sv]
// Package with sizes, constants and the sequencer state type of the rate limiter.
package pkrl_pkg;

    localparam int SLOT_COUNT  = 8;
    localparam int IDX_W       = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
    localparam int ADDR_W      = 48;
    localparam int TIME_W      = 32;
    localparam int SLOT_OUT_W  = 3;
    localparam int ENTRY_W     = ADDR_W + TIME_W;
    localparam int IN_DATA_W   = 80;
    localparam int OUT_DATA_W  = 8;

    localparam logic [TIME_W-1:0] INTERVAL_RESET = 32'd5000;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_RESOLVE,
        ST_OUT
    } state_t;

endpackage

[rtl/per_key_rate_limiter_top.sv]
// Per-address rate limiter with a slot table in memory and least-recent eviction.
//
//  Channel  Dir  Fields (low bit up)                          Handshake
//  s_*      in   source_address[47:0], time_now_ms[79:48]     s_tvalid / s_tready
//  m_*      out  allowed[0], slot_used[3:1], new_entry[4]     m_tvalid / m_tready
//  cfg_*    in   min_interval_ms[31:0]                        cfg_valid / cfg_ready
//
// One request at a time. The table memory is read one slot per cycle through a
// registered read port; the scan stops at the first hit or after the last slot.
// Reset clears the slot valid bits in flip-flops; invalid slots read as empty.
// The result waits in an output register; a stall there holds the sequencer
// until the result register is free. Configuration writes are taken every cycle.

`include "per_key_rate_limiter_top_assert.svh"

module per_key_rate_limiter_top
    import pkrl_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [IN_DATA_W-1:0]  s_tdata,   // source_address[47:0], time_now_ms[79:48]
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [OUT_DATA_W-1:0] m_tdata,   // allowed[0], slot_used[3:1], new_entry[4]
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [TIME_W-1:0]     cfg_data   // min_interval_ms[31:0]
);

    // Sequencer state
    state_t state_reg, state_next;

    // Request capture
    logic [ADDR_W-1:0] addr_reg;
    logic [TIME_W-1:0] now_reg;

    // Read issue and read pipeline
    logic [IDX_W-1:0]  rd_idx_reg;
    logic              rd_done_reg;
    logic              p_vld_reg;
    logic [IDX_W-1:0]  p_idx_reg;
    logic [ADDR_W-1:0] rdata_addr_reg;
    logic [TIME_W-1:0] rdata_time_reg;
    logic              rvld_reg;

    // Slot table and its valid bits
    logic [ENTRY_W-1:0]    mem [SLOT_COUNT];
    logic [SLOT_COUNT-1:0] vld_reg;

    // Scan results
    logic              hit_reg;
    logic [IDX_W-1:0]  hit_idx_reg;
    logic [TIME_W-1:0] hit_time_reg;
    logic [IDX_W-1:0]  old_idx_reg;
    logic [TIME_W-1:0] old_time_reg;

    // Resolved result
    logic              res_allowed_reg;
    logic [IDX_W-1:0]  res_idx_reg;
    logic              res_new_reg;

    // Output register
    logic                  m_tvalid_reg;
    logic [OUT_DATA_W-1:0] m_tdata_reg;
    logic [OUT_DATA_W-1:0] m_tdata_next;

    logic [TIME_W-1:0] interval_reg;

    // Combinational helpers
    logic              in_accept;
    logic [TIME_W-1:0] ent_time;
    logic              ent_hit;
    logic              last_eval;
    logic              scan_end;
    logic              issue;
    logic [TIME_W-1:0] elapsed;
    logic              pass;
    logic              wr_en;
    logic [IDX_W-1:0]  wr_idx;
    logic              out_load;
    logic [31:0]       res_idx_wide;

    assign in_accept = s_tvalid && s_tready;

    // Entry under evaluation; an invalid slot reads as empty
    assign ent_time  = rvld_reg ? rdata_time_reg : '0;
    assign ent_hit   = p_vld_reg && (ent_time != '0) && (rdata_addr_reg == addr_reg);
    assign last_eval = p_vld_reg && (p_idx_reg == IDX_W'(SLOT_COUNT - 1));
    assign scan_end  = ent_hit || last_eval;

    // Interval check on a hit
    assign elapsed = now_reg - hit_time_reg;
    assign pass    = (elapsed >= interval_reg);
    assign wr_idx  = hit_reg ? hit_idx_reg : old_idx_reg;

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (s_tvalid)
                    state_next = ST_SCAN;
            end
            ST_SCAN:
            begin
                if (scan_end)
                    state_next = ST_RESOLVE;
            end
            ST_RESOLVE:
            begin
                state_next = ST_OUT;
            end
            ST_OUT:
            begin
                if (!m_tvalid_reg || m_tready)
                    state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // State-decoded outputs and strobes
    always_comb
    begin
        s_tready = 1'b0;
        issue    = 1'b0;
        wr_en    = 1'b0;
        out_load = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                s_tready = 1'b1;
            end
            ST_SCAN:
            begin
                issue = !rd_done_reg && !scan_end;
            end
            ST_RESOLVE:
            begin
                wr_en = hit_reg ? pass : 1'b1;
            end
            ST_OUT:
            begin
                out_load = !m_tvalid_reg || m_tready;
            end
            default:
            begin
                s_tready = 1'b0;
            end
        endcase
    end

    assign cfg_ready = 1'b1;

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            rd_idx_reg   <= '0;
            rd_done_reg  <= 1'b0;
            p_vld_reg    <= 1'b0;
            rvld_reg     <= 1'b0;
            vld_reg      <= '0;
            hit_reg      <= 1'b0;
            m_tvalid_reg <= 1'b0;
            interval_reg <= INTERVAL_RESET;
        end
        else
        begin
            state_reg <= state_next;
            rvld_reg  <= vld_reg[rd_idx_reg];
            p_vld_reg <= issue;

            // Read issue counter
            if (in_accept)
            begin
                rd_idx_reg  <= '0;
                rd_done_reg <= 1'b0;
            end
            else if (issue)
            begin
                if (rd_idx_reg == IDX_W'(SLOT_COUNT - 1))
                    rd_done_reg <= 1'b1;
                else
                    rd_idx_reg <= rd_idx_reg + IDX_W'(1);
            end

            // Hit flag
            if (in_accept)
                hit_reg <= 1'b0;
            else if (state_reg == ST_SCAN && ent_hit)
                hit_reg <= 1'b1;

            // Slot becomes valid when written
            if (wr_en)
                vld_reg[wr_idx] <= 1'b1;

            // Output valid
            if (out_load)
                m_tvalid_reg <= 1'b1;
            else if (m_tready)
                m_tvalid_reg <= 1'b0;

            // Configuration
            if (cfg_valid && cfg_ready)
                interval_reg <= cfg_data;
        end
    end

    // Slot table: one read and one write port
    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem[wr_idx] <= {now_reg, addr_reg};
        {rdata_time_reg, rdata_addr_reg} <= mem[rd_idx_reg];
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            addr_reg <= s_tdata[ADDR_W-1:0];
            now_reg  <= s_tdata[ADDR_W+TIME_W-1:ADDR_W];
        end

        if (issue)
            p_idx_reg <= rd_idx_reg;

        // Track the match, or the oldest slot (first minimum, empty slots first)
        if (state_reg == ST_SCAN && p_vld_reg)
        begin
            if (ent_hit)
            begin
                hit_idx_reg  <= p_idx_reg;
                hit_time_reg <= ent_time;
            end
            else if (p_idx_reg == '0 || ent_time < old_time_reg)
            begin
                old_idx_reg  <= p_idx_reg;
                old_time_reg <= ent_time;
            end
        end

        // Resolve the request
        if (state_reg == ST_RESOLVE)
        begin
            res_allowed_reg <= hit_reg ? pass : 1'b1;
            res_idx_reg     <= wr_idx;
            res_new_reg     <= !hit_reg;
        end

        if (out_load)
            m_tdata_reg <= m_tdata_next;
    end

    // Result packing, slot index reduced to three bits
    always_comb
    begin
        res_idx_wide = 32'(res_idx_reg);
        m_tdata_next = '0;
        m_tdata_next[0]                = res_allowed_reg;
        m_tdata_next[SLOT_OUT_W:1]     = res_idx_wide[SLOT_OUT_W-1:0];
        m_tdata_next[SLOT_OUT_W+1]     = res_new_reg;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    // Assertions
    `PKRL_ASSERT_NEXT(a_accept_starts_scan, in_accept,
                      state_reg == ST_SCAN && rd_idx_reg == '0 && !hit_reg)
    `PKRL_ASSERT_SAME(a_result_from_seq, $rose(m_tvalid_reg), $past(state_reg == ST_OUT))
    `PKRL_ASSERT_SAME(a_refused_not_new, m_tvalid_reg, m_tdata_reg[0] || !m_tdata_reg[4])
    `PKRL_ASSERT_SAME(a_hit_occupied, state_reg == ST_RESOLVE && hit_reg,
                      hit_time_reg != '0)

endmodule

[verif/tb.sv]
// Self-checking testbench for the per-key rate limiter: stream driver, monitor and predictor.
`timescale 1ns / 100ps

module tb
    import pkrl_pkg::*;
();

    localparam int CYCLE_LIMIT = 500000;
    localparam int POOL_SIZE   = 12;
    localparam int PHASE_ITEMS = 170;

    // One lookup request as offered on the input stream
    typedef struct packed {
        logic [ADDR_W-1:0] addr;
        logic [TIME_W-1:0] now;
    } req_item_t;

    // Result fields, laid out as in m_tdata[4:0]
    typedef struct packed {
        logic                  new_entry;
        logic [SLOT_OUT_W-1:0] slot;
        logic                  allowed;
    } verdict_t;

    logic                  clk       = 1'b0;
    logic                  rst_n     = 1'b0;
    logic                  s_tvalid  = 1'b0;
    logic                  s_tready;
    logic [IN_DATA_W-1:0]  s_tdata   = '0;  // source_address[47:0], time_now_ms[79:48]
    logic                  m_tvalid;
    logic                  m_tready  = 1'b0;
    logic [OUT_DATA_W-1:0] m_tdata;         // allowed[0], slot_used[3:1], new_entry[4]
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [TIME_W-1:0]     cfg_data  = '0;  // min_interval_ms[31:0]

    // Shadow copy of the slot table and the interval register
    logic [ADDR_W-1:0] shadow_addr [SLOT_COUNT];
    logic [TIME_W-1:0] shadow_time [SLOT_COUNT];
    logic [TIME_W-1:0] shadow_gap = INTERVAL_RESET;

    req_item_t   pending_q [$];
    verdict_t    verdict_q [$];
    int          mismatch_count = 0;
    int          cycle_count    = 0;
    int          accepted_count = 0;
    logic        in_taken       = 1'b0;
    logic [TIME_W-1:0] clock_ms = '0;

    // Sender burst state, receiver stall state
    int          burst_left    = 1;
    int          gap_left      = 0;
    int          rx_phase_left = 0;
    int          rx_mode       = 0;
    logic [7:0]  rx_pattern    = 8'hFF;
    logic        rx_hold       = 1'b0;

    per_key_rate_limiter_top dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    // 12 ns clock
    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // Run limit
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("tb: errors");
            $finish;
        end
    end

    task automatic log_mismatch(input string what);
        $display("tb: mismatch at cycle %0d: %s", cycle_count, what);
        mismatch_count++;
    endtask

    // Table lookup: match, refresh or refuse; otherwise place in a free or oldest slot
    function automatic verdict_t predict_verdict(input logic [ADDR_W-1:0] addr,
                                                 input logic [TIME_W-1:0] now);
        verdict_t v;
        int free_slot;
        int oldest;
        int i;
        logic [TIME_W-1:0] elapsed;
        free_slot = -1;
        oldest = 0;
        for (i = 0; i < SLOT_COUNT; i++)
        begin
            if (shadow_time[i] != '0 && shadow_addr[i] == addr)
            begin
                elapsed = now - shadow_time[i];
                v.allowed = (elapsed >= shadow_gap);
                if (v.allowed)
                    shadow_time[i] = now;
                v.slot = SLOT_OUT_W'(i);
                v.new_entry = 1'b0;
                return v;
            end
            if (shadow_time[i] == '0 && free_slot < 0)
                free_slot = i;
            if (shadow_time[i] < shadow_time[oldest])
                oldest = i;
        end
        if (free_slot >= 0)
            oldest = free_slot;
        shadow_addr[oldest] = addr;
        shadow_time[oldest] = now;
        v.allowed = 1'b1;
        v.slot = SLOT_OUT_W'(oldest);
        v.new_entry = 1'b1;
        return v;
    endfunction

    // Rising edge: take accepted requests and results
    always @(posedge clk)
    begin : monitor
        verdict_t got;
        verdict_t want;
        in_taken <= rst_n && s_tvalid && s_tready;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (verdict_q.size() == 0)
                log_mismatch($sformatf("result %h with none pending", m_tdata));
            else
            begin
                want = verdict_q.pop_front();
                got = verdict_t'(m_tdata[4:0]);
                if (got.allowed !== want.allowed)
                    log_mismatch($sformatf("allowed %b, want %b", got.allowed, want.allowed));
                if (got.slot !== want.slot)
                    log_mismatch($sformatf("slot_used %0d, want %0d", got.slot, want.slot));
                if (got.new_entry !== want.new_entry)
                    log_mismatch($sformatf("new_entry %b, want %b",
                                           got.new_entry, want.new_entry));
                if (m_tdata[OUT_DATA_W-1:5] !== '0)
                    log_mismatch($sformatf("pad bits set in %h", m_tdata));
            end
        end
        if (rst_n && s_tvalid && s_tready)
        begin
            verdict_q.push_back(predict_verdict(s_tdata[ADDR_W-1:0],
                                                s_tdata[ADDR_W +: TIME_W]));
            accepted_count <= accepted_count + 1;
        end
    end

    // Falling edge: request driver, bursts with random gaps
    always @(negedge clk)
    begin : request_driver
        req_item_t item;
        if (rst_n && (!s_tvalid || in_taken))
        begin
            if (gap_left > 0)
            begin
                gap_left <= gap_left - 1;
                s_tvalid <= 1'b0;
            end
            else if (pending_q.size() > 0)
            begin
                item = pending_q.pop_front();
                s_tdata <= {item.now, item.addr};
                s_tvalid <= 1'b1;
                if (burst_left > 1)
                    burst_left <= burst_left - 1;
                else
                begin
                    burst_left <= $urandom_range(16, 1);
                    gap_left <= ($urandom_range(3, 0) == 0) ? 0 : $urandom_range(8, 1);
                end
            end
            else
                s_tvalid <= 1'b0;
        end
    end

    // Falling edge: result receiver, stall mode is redrawn when its phase counter runs out
    always @(negedge clk)
    begin
        if (rx_phase_left == 0)
        begin
            rx_mode <= $urandom_range(2, 0);
            rx_pattern <= 8'($urandom());
            rx_phase_left <= $urandom_range(80, 20);
        end
        else
            rx_phase_left <= rx_phase_left - 1;
        if (rx_hold)
            m_tready <= 1'b0;
        else if (rx_mode == 0)
            m_tready <= 1'b1;
        else if (rx_mode == 1)
            m_tready <= 1'($urandom_range(1, 0));
        else
            m_tready <= rx_pattern[3'(rx_phase_left)];
    end

    // Long receiver hold-off while requests keep coming
    initial
    begin : rx_holdoff
        wait (accepted_count >= 400);
        @(posedge clk);
        rx_hold = 1'b1;
        repeat (400) @(posedge clk);
        rx_hold = 1'b0;
    end

    function automatic logic [ADDR_W-1:0] rand_addr();
        return {16'($urandom()), 32'($urandom())};
    endfunction

    function automatic logic [TIME_W-1:0] span_for(input logic [TIME_W-1:0] interval);
        if (interval == '0)
            return 32'd1000;
        if (interval > 32'h7FFF_FFFF)
            return 32'hFFFF_FFFF;
        return interval * 2;
    endfunction

    task automatic push_req(input logic [ADDR_W-1:0] addr, input logic [TIME_W-1:0] now);
        req_item_t item;
        item.addr = addr;
        item.now = now;
        pending_q.push_back(item);
    endtask

    // Extremes, wrap, time zero, eviction by oldest and by tie
    task automatic queue_directed();
        push_req(48'h0, 32'd1);
        push_req(48'h0, 32'd5000);             // one short of the interval
        push_req(48'h0, 32'd5001);             // exactly the interval
        push_req(48'hFFFF_FFFF_FFFF, 32'hFFFF_FFFF);
        push_req(48'hFFFF_FFFF_FFFF, 32'd4000); // wrapped, too soon
        push_req(48'hFFFF_FFFF_FFFF, 32'd4999); // wrapped, just enough
        push_req(48'hAAAA_AAAA_AAAA, 32'd0);   // stored time zero leaves the slot empty
        push_req(48'hAAAA_AAAA_AAAA, 32'd10);
        push_req(48'h5555_5555_5555, 32'd100);
        push_req(48'h0000_0000_0001, 32'd50);
        push_req(48'h8000_0000_0000, 32'd50);  // ties with the one before
        push_req(48'h1234_5678_9ABC, 32'd300);
        push_req(48'h0F0F_0F0F_0F0F, 32'h8000_0000);
        push_req(48'h0F0F_0F0F_0F0F, 32'h8000_0001);
        push_req(48'hC0DE_0000_0001, 32'd600); // table full: evicts smallest time
        push_req(48'hC0DE_0000_0002, 32'd700); // tie, lower slot goes first
        push_req(48'hC0DE_0000_0003, 32'd800);
        push_req(48'h5555_5555_5555, 32'd0);   // hit at time zero empties the slot
        push_req(48'hC0DE_0000_0004, 32'd900); // takes the slot just emptied
    endtask

    // Traffic from a small address pool with advancing time, plus noise
    task automatic queue_random(input int count, input logic [TIME_W-1:0] span);
        logic [ADDR_W-1:0] pool [POOL_SIZE];
        int n;
        int pick;
        for (n = 0; n < POOL_SIZE; n++)
            pool[n] = rand_addr();
        for (n = 0; n < count; n++)
        begin
            pick = $urandom_range(99, 0);
            clock_ms += TIME_W'($urandom_range(span, 0));
            if (pick >= 97)
                push_req(pool[$urandom_range(POOL_SIZE - 1, 0)], '0);
            else if (pick >= 94)
            begin
                clock_ms = $urandom();
                push_req(pool[$urandom_range(POOL_SIZE - 1, 0)], clock_ms);
            end
            else if (pick >= 84)
                push_req(rand_addr(), clock_ms);
            else
                push_req(pool[$urandom_range(POOL_SIZE - 1, 0)], clock_ms);
        end
    endtask

    // Hold until every request is sent and every result is back
    task automatic wait_drained();
        do
            @(negedge clk);
        while (pending_q.size() != 0 || s_tvalid || verdict_q.size() != 0);
        repeat (4) @(negedge clk);
    endtask

    task automatic write_interval(input logic [TIME_W-1:0] value);
        @(negedge clk);
        cfg_data <= value;
        cfg_valid <= 1'b1;
        do
            @(posedge clk);
        while (!cfg_ready);
        shadow_gap = value;
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    // Main sequence: reset, default interval, then one phase per interval setting
    initial
    begin : stimulus
        logic [TIME_W-1:0] phase_interval [5];
        int p;
        for (p = 0; p < SLOT_COUNT; p++)
        begin
            shadow_addr[p] = '0;
            shadow_time[p] = '0;
        end
        phase_interval[0] = '0;
        phase_interval[1] = 32'hFFFF_FFFF;
        phase_interval[2] = 32'd1;
        phase_interval[3] = $urandom_range(100000, 2);
        phase_interval[4] = INTERVAL_RESET;
        rst_n = 1'b0;
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        clock_ms = 32'd1000;
        queue_directed();
        queue_random(PHASE_ITEMS, span_for(shadow_gap));
        wait_drained();

        for (p = 0; p < 5; p++)
        begin
            write_interval(phase_interval[p]);
            if (phase_interval[p] == 32'hFFFF_FFFF)
            begin
                // elapsed of all ones is the only pass at the top interval
                push_req(48'hFEED_FACE_0001, 32'h1234_5678);
                push_req(48'hFEED_FACE_0001, 32'h1234_5677);
            end
            queue_random(PHASE_ITEMS, span_for(phase_interval[p]));
            wait_drained();
        end

        repeat (16) @(negedge clk);
        if (mismatch_count == 0)
            $display("tb: clean");
        else
            $display("tb: errors");
        $finish;
    end

endmodule

[filelist.f]
+incdir+rtl
rtl/pkrl_pkg.sv
rtl/per_key_rate_limiter_top.sv
verif/tb.sv
